// ===== hdl/sdf_volume_trilinear_sampler_top_defines.svh =====
// Assertion macros for the top-level RTL file of the sampler.
`ifndef SDF_VOLUME_TRILINEAR_SAMPLER_TOP_DEFINES_SVH
`define SDF_VOLUME_TRILINEAR_SAMPLER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SDFVT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SDFVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDFVT_ASSERT(lbl, clk, rstn, prop, msg)
`define SDFVT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/sdfvt_pkg.sv =====
package sdfvt_pkg;

  localparam int MAX_RESOLUTION_DEF = 32;
  localparam int MAX_VOLUMES_DEF    = 4;
  localparam int SAMPLE_BITS_DEF    = 16;

  localparam int RES_W   = 6;
  localparam int VL_W    = 3;
  localparam int VID_W   = 2;
  localparam int IDX_W   = 15;
  localparam int PT_W    = 16;
  localparam int DIST_W  = 20;
  localparam int CFG_W   = 6;
  localparam int FRAC_W  = 13;

  localparam int ONE_Q12   = 4096;
  localparam int SQRT3_Q12 = 7094;
  localparam int RES_RESET = 32;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 20'sd524287;
  localparam logic signed [DIST_W-1:0] DIST_MIN = -20'sd524288;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [0:0] CFG_RESOLUTION     = 1'b0;
  localparam logic [0:0] CFG_VOLUMES_LOADED = 1'b1;

endpackage

// ===== hdl/sdfvt_if.sv =====
interface sdfvt_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [sdfvt_pkg::VID_W-1:0]         volume_id;
  logic [sdfvt_pkg::IDX_W-1:0]         voxel_index;
  logic signed [sdfvt_pkg::PT_W-1:0]   sample_value;
  logic signed [sdfvt_pkg::PT_W-1:0]   point_x;
  logic signed [sdfvt_pkg::PT_W-1:0]   point_y;
  logic signed [sdfvt_pkg::PT_W-1:0]   point_z;

  modport source (output valid, cmd, volume_id, voxel_index, sample_value,
                  point_x, point_y, point_z, input ready);
  modport sink   (input valid, cmd, volume_id, voxel_index, sample_value,
                  point_x, point_y, point_z, output ready);
endinterface

interface sdfvt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sdfvt_pkg::DIST_W-1:0] distance;
  logic                                found;

  modport source (output valid, distance, found, input ready);
  modport sink   (input valid, distance, found, output ready);
endinterface

// ===== hdl/sdfvt_ram.sv =====
module sdfvt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hdl/sdf_volume_trilinear_sampler_top.sv =====
// Channel | Dir | Fields
// in_i    | in  | cmd, volume_id, voxel_index, sample_value, point_x/y/z
// out_o   | out | distance, found (one beat per query, none per write)
// cfg     | in  | cfg_we_i, cfg_index_i, cfg_wdata_i (resolution, volumes_loaded)
// Writes pass PREP and WRITE; unloaded queries skip to FIN. A loaded query makes
// one shared multiplier pass per axis, eight reads through the single sample
// memory port, seven passes of one lerp unit; the 16-step root runs alongside.
// Reset is asynchronous and active low; the sample memory is not cleared.
// A finished beat waits in the output register; a later query stalls before
// loading it until out_o is taken.
`include "sdf_volume_trilinear_sampler_top_defines.svh"

module sdf_volume_trilinear_sampler_top #(
  parameter int MAX_RESOLUTION = sdfvt_pkg::MAX_RESOLUTION_DEF,
  parameter int MAX_VOLUMES    = sdfvt_pkg::MAX_VOLUMES_DEF,
  parameter int SAMPLE_BITS    = sdfvt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sdfvt_in_if.sink                     in_i,
  sdfvt_out_if.source                  out_o,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_index_i,
  input  logic [sdfvt_pkg::CFG_W-1:0]  cfg_wdata_i
);

  localparam int VOL_STRIDE = MAX_RESOLUTION * MAX_RESOLUTION * MAX_RESOLUTION;
  localparam int DEPTH      = MAX_VOLUMES * VOL_STRIDE;
  localparam int AW         = $clog2(DEPTH);
  localparam int SW         = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int RW         = sdfvt_pkg::RES_W;
  localparam int FW         = sdfvt_pkg::FRAC_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_WRITE = 9'b000000100,
    S_AXIS  = 9'b000001000,
    S_OFFS  = 9'b000010000,
    S_READ  = 9'b000100000,
    S_LERP  = 9'b001000000,
    S_ROOT  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [RW-1:0]                  res_q;
  logic [sdfvt_pkg::VL_W-1:0]     vl_q;
  logic                           cmd_q, huge_q;
  logic [sdfvt_pkg::VID_W-1:0]    vid_q;
  logic [sdfvt_pkg::IDX_W-1:0]    idx_q;
  logic signed [sdfvt_pkg::PT_W-1:0] smp_q, px_q, py_q, pz_q;
  logic [2*RW-1:0]                res2_q;
  logic [1:0]                     ax_q;
  logic [2:0]                     cnt_q;
  logic [RW-1:0]                  lo_q [3];
  logic [RW-1:0]                  hi_q [3];
  logic [FW-1:0]                  t_q  [3];
  logic [31:0]                    osq_q;
  logic [2*RW-1:0]                yo_q [2];
  logic [3*RW-1:0]                zo_q [2];
  logic signed [SW-1:0]           c_q  [8];
  logic                           cap_q;
  logic [2:0]                     cap_idx_q;
  logic [4:0]                     sq_cnt_q;
  logic [31:0]                    sq_v_q, sq_r_q;
  logic [30:0]                    sq_bit_q;
  logic [RW:0]                    dv_rem_q;
  logic [12:0]                    dv_quo_q;
  logic                           ovalid_q;
  logic signed [sdfvt_pkg::DIST_W-1:0] dist_q;
  logic                           found_q;

  logic [RW-1:0] eres;
  always_comb begin
    if (res_q < RW'(2)) begin
      eres = RW'(2);
    end else if (int'(res_q) > MAX_RESOLUTION) begin
      eres = RW'(MAX_RESOLUTION);
    end else begin
      eres = res_q;
    end
  end

  logic accept, loaded;
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign loaded     = (int'(in_i.volume_id) < int'(vl_q)) &&
                      (int'(in_i.volume_id) < MAX_VOLUMES);

  // Per-axis grid mapping.
  logic signed [sdfvt_pkg::PT_W-1:0] p_ax;
  logic signed [sdfvt_pkg::PT_W:0]   c_ax, ap_ax;
  logic [14:0]                       o_ax;
  logic [13:0]                       cs_ax;
  logic [19:0]                       g_ax, gmax;
  logic [RW-1:0]                     lo_ax, hi_ax;
  always_comb begin
    unique case (ax_q)
      2'd0:    p_ax = px_q;
      2'd1:    p_ax = py_q;
      default: p_ax = pz_q;
    endcase
    if (p_ax < -16'sd4096) begin
      c_ax = -17'sd4096;
    end else if (p_ax > 16'sd4096) begin
      c_ax = 17'sd4096;
    end else begin
      c_ax = 17'(p_ax);
    end
    ap_ax = (p_ax < 0) ? -17'(p_ax) : 17'(p_ax);
    o_ax  = (ap_ax > 17'sd4096) ? 15'(ap_ax - 17'sd4096) : 15'd0;
    cs_ax = 14'(c_ax + 17'sd4096);
    gmax  = 20'(eres - RW'(1)) << FW;
    g_ax  = 20'(cs_ax) * 20'(eres);
    if (g_ax > gmax) begin
      g_ax = gmax;
    end
    lo_ax = g_ax[FW +: RW];
    hi_ax = (lo_ax + RW'(1) < eres) ? lo_ax + RW'(1) : eres - RW'(1);
  end

  // Shared lerp unit.
  logic [2:0]            la, lb;
  logic [FW-1:0]         lt;
  logic signed [SW:0]    ldiff;
  logic signed [SW+14:0] lprod, lsum;
  always_comb begin
    unique case (cnt_q)
      3'd0:    begin la = 3'd0; lb = 3'd1; lt = t_q[0]; end
      3'd1:    begin la = 3'd2; lb = 3'd3; lt = t_q[0]; end
      3'd2:    begin la = 3'd4; lb = 3'd5; lt = t_q[0]; end
      3'd3:    begin la = 3'd6; lb = 3'd7; lt = t_q[0]; end
      3'd4:    begin la = 3'd0; lb = 3'd2; lt = t_q[1]; end
      3'd5:    begin la = 3'd4; lb = 3'd6; lt = t_q[1]; end
      default: begin la = 3'd0; lb = 3'd4; lt = t_q[2]; end
    endcase
    ldiff = (SW+1)'(c_q[lb]) - (SW+1)'(c_q[la]);
    lprod = ldiff * $signed({1'b0, lt});
    lsum  = (SW+15)'(c_q[la]) + (lprod >>> FW);
  end

  // Memory addressing.
  logic [AW-1:0]          base, ram_addr;
  logic                   ram_we;
  logic [3*RW-1:0]        res3;
  logic [SAMPLE_BITS-1:0] ram_rdata, ram_wdata;
  always_comb begin
    base      = AW'(vid_q) * AW'(VOL_STRIDE);
    res3      = (3*RW)'(res2_q) * (3*RW)'(eres);
    ram_wdata = SAMPLE_BITS'($signed(smp_q[SW-1:0]));
    ram_we    = 1'b0;
    if (state_q == S_WRITE) begin
      ram_addr = base + AW'(idx_q);
      ram_we   = (int'(vid_q) < MAX_VOLUMES) && ((3*RW)'(idx_q) < res3);
    end else begin
      ram_addr = base + AW'(cnt_q[0] ? hi_q[0] : lo_q[0])
               + AW'(yo_q[cnt_q[1]]) + AW'(zo_q[cnt_q[2]]);
    end
  end

  sdfvt_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Root and margin step.
  logic [32:0]  sq_try;
  logic [RW+1:0] dv_try;
  logic [12:0]  dv_num;
  logic [3:0]   dv_bit;
  assign sq_try = 33'(sq_r_q) + 33'(sq_bit_q);
  assign dv_num = 13'(sdfvt_pkg::SQRT3_Q12) + 13'(eres >> 1);
  assign dv_bit = 4'(sq_cnt_q - 5'd1);
  assign dv_try = {dv_rem_q, dv_num[dv_bit]};

  logic signed [21:0] fsum;
  logic               out_free;
  assign fsum = 22'(c_q[0]) + 22'(sq_r_q[15:0]) - 22'(dv_quo_q);
  assign out_free = !ovalid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.cmd == sdfvt_pkg::CMD_QUERY && !loaded) begin
            state_d = S_FIN;
          end else begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP:  state_d = (cmd_q == sdfvt_pkg::CMD_WRITE) ? S_WRITE : S_AXIS;
      S_WRITE: state_d = S_IDLE;
      S_AXIS:  state_d = (ax_q == 2'd2) ? S_OFFS : S_AXIS;
      S_OFFS:  state_d = S_READ;
      S_READ:  state_d = (cnt_q == 3'd7) ? S_LERP : S_READ;
      S_LERP:  state_d = (cnt_q == 3'd6) ? S_ROOT : S_LERP;
      S_ROOT:  state_d = (sq_cnt_q == 5'd0) ? S_FIN : S_ROOT;
      S_FIN:   state_d = out_free ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      res_q    <= RW'(sdfvt_pkg::RES_RESET);
      vl_q     <= '0;
      ovalid_q <= 1'b0;
      cap_q    <= 1'b0;
      sq_cnt_q <= '0;
      ax_q     <= '0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sdfvt_pkg::CFG_RESOLUTION:     res_q <= cfg_wdata_i[RW-1:0];
          sdfvt_pkg::CFG_VOLUMES_LOADED: vl_q  <= cfg_wdata_i[sdfvt_pkg::VL_W-1:0];
          default: ;
        endcase
      end
      cap_q <= (state_q == S_READ);
      if (state_q == S_PREP) begin
        ax_q  <= '0;
        cnt_q <= '0;
      end else if (state_q == S_AXIS) begin
        ax_q <= ax_q + 2'd1;
      end else if (state_q == S_READ || state_q == S_LERP) begin
        cnt_q <= (state_q == S_READ && cnt_q == 3'd7) ? 3'd0 : cnt_q + 3'd1;
      end
      if (state_q == S_OFFS) begin
        sq_cnt_q <= 5'd16;
      end else if (sq_cnt_q != 5'd0) begin
        sq_cnt_q <= sq_cnt_q - 5'd1;
      end
      if (state_q == S_FIN && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_i.cmd;
      vid_q  <= in_i.volume_id;
      idx_q  <= in_i.voxel_index;
      smp_q  <= in_i.sample_value;
      px_q   <= in_i.point_x;
      py_q   <= in_i.point_y;
      pz_q   <= in_i.point_z;
      huge_q <= (in_i.cmd == sdfvt_pkg::CMD_QUERY) && !loaded;
      osq_q  <= '0;
    end
    if (state_q == S_PREP) begin
      res2_q <= (2*RW)'(eres) * (2*RW)'(eres);
    end
    if (state_q == S_AXIS) begin
      lo_q[ax_q] <= lo_ax;
      hi_q[ax_q] <= hi_ax;
      t_q[ax_q]  <= g_ax[FW-1:0];
      osq_q      <= osq_q + 32'(30'(o_ax) * 30'(o_ax));
    end
    if (state_q == S_OFFS) begin
      yo_q[0] <= (2*RW)'(lo_q[1]) * (2*RW)'(eres);
      yo_q[1] <= (2*RW)'(hi_q[1]) * (2*RW)'(eres);
      zo_q[0] <= (3*RW)'(lo_q[2]) * (3*RW)'(res2_q);
      zo_q[1] <= (3*RW)'(hi_q[2]) * (3*RW)'(res2_q);
      sq_v_q   <= osq_q;
      sq_r_q   <= '0;
      sq_bit_q <= 31'h40000000;
      dv_rem_q <= '0;
      dv_quo_q <= '0;
    end else if (sq_cnt_q != 5'd0) begin
      if ({1'b0, sq_v_q} >= sq_try) begin
        sq_v_q <= 32'({1'b0, sq_v_q} - sq_try);
        sq_r_q <= (sq_r_q >> 1) + 32'(sq_bit_q);
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
      if (sq_cnt_q <= 5'd13) begin
        if (dv_try >= (RW+2)'(eres)) begin
          dv_rem_q <= (RW+1)'(dv_try - (RW+2)'(eres));
          dv_quo_q <= {dv_quo_q[11:0], 1'b1};
        end else begin
          dv_rem_q <= (RW+1)'(dv_try);
          dv_quo_q <= {dv_quo_q[11:0], 1'b0};
        end
      end
    end
    if (state_q == S_READ) begin
      cap_idx_q <= cnt_q;
    end
    if (cap_q) begin
      c_q[cap_idx_q] <= $signed(ram_rdata[SW-1:0]);
    end
    if (state_q == S_LERP) begin
      c_q[la] <= SW'(lsum);
    end
    if (state_q == S_FIN && out_free) begin
      found_q <= !huge_q;
      if (huge_q || fsum > 22'(sdfvt_pkg::DIST_MAX)) begin
        dist_q <= sdfvt_pkg::DIST_MAX;
      end else if (fsum < 22'(sdfvt_pkg::DIST_MIN)) begin
        dist_q <= sdfvt_pkg::DIST_MIN;
      end else begin
        dist_q <= 20'(fsum);
      end
    end
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.distance = dist_q;
  assign out_o.found    = found_q;

  `SDFVT_ASSERT(a_rose_from_fin, clk_i, rst_ni, $rose(ovalid_q) |-> $past(state_q == S_FIN), "output beat without a finished query")
  `SDFVT_ASSERT(a_unfound_huge, clk_i, rst_ni, ovalid_q && !found_q |-> dist_q == sdfvt_pkg::DIST_MAX, "unloaded query without huge distance")
  `SDFVT_ASSERT(a_root_on_time, clk_i, rst_ni, state_q == S_LERP |-> sq_cnt_q != 5'd0, "root finished before interpolation")
  `SDFVT_ASSERT(a_busy_after_beat, clk_i, rst_ni, accept |=> state_q != S_IDLE, "accepted beat left no work")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sdfvt_pkg::*;

  localparam int STORE_STRIDE = MAX_RESOLUTION_DEF ** 3;
  localparam int STORE_DEPTH  = MAX_VOLUMES_DEF * STORE_STRIDE;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_TARGET  = 700;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic                     found;
  } dist_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  sdfvt_in_if  in_if ();
  sdfvt_out_if out_if ();

  sdf_volume_trilinear_sampler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic signed [PT_W-1:0] voxel_mem [STORE_DEPTH];
  bit                     voxel_written [STORE_DEPTH];
  int unsigned            res_reg;
  int unsigned            loaded_reg;
  dist_result_t           pending_dist[$];

  int  mismatch_count;
  int  query_count;
  int  write_count;
  int  beat_count;
  int  cycle_count;
  bit  quiet;
  int  rx_stall_left;
  int  rx_run_left;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_dist.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned grid_res();
    if (res_reg < 2) return 2;
    if (res_reg > MAX_RESOLUTION_DEF) return MAX_RESOLUTION_DEF;
    return res_reg;
  endfunction

  function automatic int unsigned usable_volumes();
    return (loaded_reg > MAX_VOLUMES_DEF) ? MAX_VOLUMES_DEF : loaded_reg;
  endfunction

  task automatic axis_cell(input logic signed [PT_W-1:0] p, output int unsigned lo,
                           output int unsigned hi, output longint t);
    longint c;
    longint g;
    int unsigned res;
    res = grid_res();
    c = p;
    if (c < -ONE_Q12) c = -ONE_Q12;
    if (c > ONE_Q12) c = ONE_Q12;
    g = (c + ONE_Q12) * longint'(res);
    if (g > (longint'(res - 1) << FRAC_W)) g = longint'(res - 1) << FRAC_W;
    lo = int'(g >>> FRAC_W);
    t = g & 8191;
    hi = (lo + 1 < res) ? lo + 1 : res - 1;
  endtask

  function automatic int unsigned voxel_addr(int unsigned vid, int unsigned x,
                                             int unsigned y, int unsigned z);
    int unsigned res;
    res = grid_res();
    return vid * STORE_STRIDE + x + res * y + res * res * z;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> FRAC_W);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(r);
  endfunction

  task automatic predict_distance(input int unsigned vid, input logic signed [PT_W-1:0] px,
                                  input logic signed [PT_W-1:0] py,
                                  input logic signed [PT_W-1:0] pz,
                                  output dist_result_t res_out);
    logic signed [PT_W-1:0] pt [3];
    int unsigned lo [3];
    int unsigned hi [3];
    longint t [3];
    longint corner [8];
    longint ap;
    longint o;
    longint unsigned osq;
    longint e00, e10, e01, e11, f0, f1, s, d, margin;
    int unsigned res;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    res = grid_res();
    if (vid >= usable_volumes()) begin
      res_out.distance = DIST_MAX;
      res_out.found = 1'b0;
      return;
    end
    osq = 0;
    for (int k = 0; k < 3; k++) begin
      axis_cell(pt[k], lo[k], hi[k], t[k]);
      ap = pt[k];
      if (ap < 0) ap = -ap;
      o = (ap > ONE_Q12) ? ap - ONE_Q12 : 0;
      osq += longint'(o * o);
    end
    for (int n = 0; n < 8; n++) begin
      corner[n] = voxel_mem[voxel_addr(vid, n[0] ? hi[0] : lo[0], n[1] ? hi[1] : lo[1],
                                       n[2] ? hi[2] : lo[2])];
    end
    e00 = blend(corner[0], corner[1], t[0]);
    e10 = blend(corner[2], corner[3], t[0]);
    e01 = blend(corner[4], corner[5], t[0]);
    e11 = blend(corner[6], corner[7], t[0]);
    f0 = blend(e00, e10, t[1]);
    f1 = blend(e01, e11, t[1]);
    s = blend(f0, f1, t[2]);
    margin = (SQRT3_Q12 + res / 2) / res;
    d = s + int_sqrt(osq) - margin;
    if (d > 524287) d = 524287;
    if (d < -524288) d = -524288;
    res_out.distance = d[DIST_W-1:0];
    res_out.found = 1'b1;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("Mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  always @(posedge clk_i) begin
    dist_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      beat_count++;
      if (pending_dist.size() == 0) begin
        report("unexpected beat, distance", out_if.distance, 0);
      end else begin
        want = pending_dist.pop_front();
        if (out_if.distance !== want.distance) report("distance", out_if.distance, want.distance);
        if (out_if.found !== want.found) report("found", out_if.found, want.found);
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet) begin
      out_if.ready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (rx_run_left > 0) begin
      rx_run_left <= rx_run_left - 1;
      out_if.ready <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      rx_stall_left <= $urandom_range(1, 8) - 1;
      out_if.ready <= 1'b0;
    end else begin
      rx_run_left <= $urandom_range(0, 30);
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic cmd, input int unsigned vid, input int unsigned idx,
                           input logic signed [PT_W-1:0] sample,
                           input logic signed [PT_W-1:0] px, input logic signed [PT_W-1:0] py,
                           input logic signed [PT_W-1:0] pz);
    dist_result_t want;
    int unsigned addr;
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.volume_id <= vid[VID_W-1:0];
    in_if.voxel_index <= idx[IDX_W-1:0];
    in_if.sample_value <= sample;
    in_if.point_x <= px;
    in_if.point_y <= py;
    in_if.point_z <= pz;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    if (cmd == CMD_WRITE) begin
      write_count++;
      if (idx[IDX_W-1:0] < grid_res() ** 3) begin
        addr = vid * STORE_STRIDE + idx[IDX_W-1:0];
        voxel_mem[addr] = sample;
        voxel_written[addr] = 1'b1;
      end
    end else begin
      query_count++;
      predict_distance(vid, px, py, pz, want);
      pending_dist = {pending_dist, want};
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_RESOLUTION) res_reg = value & 6'h3f;
    else loaded_reg = value & 3'h7;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned res, input int unsigned loaded);
    wait_idle();
    cfg_write(CFG_RESOLUTION, res);
    cfg_write(CFG_VOLUMES_LOADED, loaded);
  endtask

  function automatic logic signed [PT_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Every corner a loaded query reads must hold a written sample first.
  task automatic query_point(input int unsigned vid, input logic signed [PT_W-1:0] px,
                             input logic signed [PT_W-1:0] py,
                             input logic signed [PT_W-1:0] pz);
    int unsigned lo [3];
    int unsigned hi [3];
    longint t [3];
    int unsigned x, y, z, res;
    axis_cell(px, lo[0], hi[0], t[0]);
    axis_cell(py, lo[1], hi[1], t[1]);
    axis_cell(pz, lo[2], hi[2], t[2]);
    res = grid_res();
    if (vid < usable_volumes()) begin
      for (int n = 0; n < 8; n++) begin
        x = n[0] ? hi[0] : lo[0];
        y = n[1] ? hi[1] : lo[1];
        z = n[2] ? hi[2] : lo[2];
        if (!voxel_written[voxel_addr(vid, x, y, z)])
          send_item(CMD_WRITE, vid, x + res * y + res * res * z, rand_sample(), 0, 0, 0);
      end
    end
    send_item(CMD_QUERY, vid, $urandom, 16'($urandom), px, py, pz);
  endtask

  function automatic logic signed [PT_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return $urandom_range(0, 1) ? 16'sd4096 : -16'sd4096;
      default: return $signed(16'($urandom_range(0, 10000))) - 16'sd5000;
    endcase
  endfunction

  task automatic test_unloaded_after_reset();
    query_point(0, 0, 0, 0);
    query_point(3, 16'sh7fff, 16'sh8000, 0);
  endtask

  task automatic test_directed();
    set_config(4, 2);
    send_item(CMD_WRITE, 0, 64, 16'sh1234, 0, 0, 0);
    send_item(CMD_WRITE, 1, 32767, 16'sh8000, 0, 0, 0);
    send_item(CMD_WRITE, 3, 5, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    query_point(0, 0, 0, 0);
    query_point(0, -16'sd4096, -16'sd4096, -16'sd4096);
    query_point(0, 16'sd4096, 16'sd4096, 16'sd4096);
    query_point(1, 16'sd4097, -16'sd4097, 16'sd1);
    query_point(1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    query_point(1, 16'sh8000, 16'sh8000, 16'sh8000);
    query_point(0, 16'sh7fff, 16'sh8000, 16'sd2048);
    query_point(2, 16'sd100, 16'sd100, 16'sd100);
    query_point(3, 16'sh8000, 0, 16'sh7fff);
    for (int k = 0; k < 8; k++) send_item(CMD_WRITE, 1, k, 16'sh7fff, 0, 0, 0);
    query_point(1, -16'sd4096, -16'sd4096, -16'sd4096);
    for (int k = 0; k < 8; k++) send_item(CMD_WRITE, 2, k, 16'sh8000, 0, 0, 0);
    set_config(4, 4);
    query_point(2, -16'sd4096, -16'sd4096, -16'sd4096);
    query_point(3, 16'sh1555, 16'sh0aaa, -16'sh0aaa);
  endtask

  task automatic test_config_range();
    set_config(0, 7);
    query_point(0, 16'sh8000, 16'sh7fff, 0);
    query_point(3, 16'sd1234, -16'sd1234, 16'sd4000);
    set_config(63, 5);
    query_point(1, 0, 0, 16'sh7fff);
    set_config(32, 4);
    query_point(2, 16'sd4095, 16'sd4095, -16'sd4095);
  endtask

  task automatic random_phase(input int unsigned res, input int unsigned loaded,
                              input int stop_at);
    int unsigned vid;
    set_config(res, loaded);
    while (write_count + query_count < stop_at) begin
      if ($urandom_range(0, 5) == 0) begin
        vid = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
          send_item(CMD_WRITE, vid, $urandom, 16'($urandom), 0, 0, 0);
        else send_item(CMD_WRITE, vid, $urandom_range(0, grid_res() ** 3 - 1), rand_sample(),
                       16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        if (usable_volumes() > 0 && $urandom_range(0, 5) != 0)
          vid = $urandom_range(0, usable_volumes() - 1);
        else vid = $urandom_range(0, 3);
        query_point(vid, rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  task automatic test_random();
    int unsigned res_list [10] = '{2, 3, 5, 32, 4, 17, 1, 8, 2, 6};
    int base;
    int share;
    base = write_count + query_count;
    share = (ITEM_TARGET > base + 200) ? (ITEM_TARGET - base) / 10 : 20;
    for (int p = 0; p < 10; p++) begin
      if (p == 9) begin
        wait_idle();
        quiet = 1'b1;
      end
      random_phase(res_list[p], (p == 0) ? 4 : $urandom_range(0, 7), base + (p + 1) * share);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_WRITE;
    in_if.volume_id = '0;
    in_if.voxel_index = '0;
    in_if.sample_value = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    out_if.ready = 1'b0;
    res_reg = RES_RESET;
    loaded_reg = 0;
    mismatch_count = 0;
    query_count = 0;
    write_count = 0;
    beat_count = 0;
    cycle_count = 0;
    quiet = 1'b0;
    rx_stall_left = 0;
    rx_run_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unloaded_after_reset();
    test_directed();
    test_config_range();
    test_random();

    wait_idle();
    $display("Sent %0d sample writes and %0d distance queries; %0d result beats checked.",
             write_count, query_count, beat_count);
    $display("Resolutions from the clamped low end to the full grid, all load counts.");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sdfvt_pkg.sv
hdl/sdfvt_if.sv
hdl/sdfvt_ram.sv
hdl/sdf_volume_trilinear_sampler_top.sv
bench/tb.sv
